// ===== src/occupancy_grid_rasterizer_defines.svh =====
// Assertion macros for the occupancy grid rasterizer.
// Used by the top level; needs clk and rst_n in scope.
`ifndef OCCUPANCY_GRID_RASTERIZER_DEFINES_SVH
`define OCCUPANCY_GRID_RASTERIZER_DEFINES_SVH
`ifndef SYNTH
`define OGR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OGR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OGR_ASSERT_IMP(label, ante, cons, msg)
`define OGR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== src/ogr_pkg.sv =====
// Shared types, constants and codes of the occupancy grid rasterizer.
// No dependencies.
package ogr_pkg;
    localparam int MAX_COLS   = 256;
    localparam int MAX_ROWS   = 256;
    localparam int MAX_KERNEL = 32;

    localparam int CA_W    = $clog2(MAX_COLS);
    localparam int EC_W    = $clog2(MAX_COLS + 1);
    localparam int ER_W    = $clog2(MAX_ROWS + 1);
    localparam int RES_W   = 16;
    localparam int DIV_W   = 25;
    localparam int SW      = DIV_W + 2;
    localparam int PADDR_W = 5;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_RESOLUTION  = 3'd2,
        REG_GRID_COLS   = 3'd3,
        REG_GRID_ROWS   = 3'd4,
        REG_KERNEL_COLS = 3'd5,
        REG_KERNEL_ROWS = 3'd6,
        REG_OCC_VALUE   = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_PT_RD,
        S_PT_WR,
        S_RC_RD,
        S_RC_WR,
        S_Q_RD,
        S_RES
    } state_t;

    typedef struct packed {
        func_t              func;
        logic signed [23:0] map_x;
        logic signed [23:0] map_y;
        logic               dilate;
        logic               new_cloud;
        logic [15:0]        cell_index;
    } in_word_t;

    typedef struct packed {
        logic [7:0] occupancy;
        logic       in_grid;
    } out_word_t;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [15:0]        resolution;
        logic [8:0]         grid_cols;
        logic [8:0]         grid_rows;
        logic [5:0]         kernel_cols;
        logic [5:0]         kernel_rows;
        logic [7:0]         occupied_value;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num_a;
        logic [DIV_W-1:0] num_b;
        logic [RES_W-1:0] den;
    } div_req_t;
endpackage

// ===== src/ogr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ogr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== src/ogr_div.sv =====
// Two-lane restoring divider, one quotient bit per lane each cycle.
// Depends on ogr_pkg.
module ogr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ogr_pkg::div_req_t         req,
    output logic                      done,
    output logic [ogr_pkg::DIV_W-1:0] quo_a,
    output logic [ogr_pkg::DIV_W-1:0] quo_b,
    output logic [ogr_pkg::RES_W-1:0] rem_a
);
    import ogr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic [RES_W-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [RES_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [RES_W:0]   trial_a, trial_b;

    always_comb
    begin
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial_a   = {ra_reg, qa_reg[DIV_W-1]};
        trial_b   = {rb_reg, qb_reg[DIV_W-1]};
        if (req.start)
        begin
            qa_next   = req.num_a;
            qb_next   = req.num_b;
            ra_next   = '0;
            rb_next   = '0;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial_a >= {1'b0, den_reg})
            begin
                ra_next = RES_W'(trial_a - {1'b0, den_reg});
                qa_next = {qa_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                ra_next = RES_W'(trial_a);
                qa_next = {qa_reg[DIV_W-2:0], 1'b0};
            end
            if (trial_b >= {1'b0, den_reg})
            begin
                rb_next = RES_W'(trial_b - {1'b0, den_reg});
                qb_next = {qb_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rb_next = RES_W'(trial_b);
                qb_next = {qb_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_reg <= qa_next;
        qb_reg <= qb_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign done  = done_reg;
    assign quo_a = qa_reg;
    assign quo_b = qb_reg;
    assign rem_a = ra_reg;
endmodule

// ===== src/ogr_cfg.sv =====
// APB-style configuration register file.
// Depends on ogr_pkg.
module ogr_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ogr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ogr_pkg::cfg_t               cfg
);
    import ogr_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_ORIGIN_X:    cfg_next.origin_x       = pwdata[15:0];
                REG_ORIGIN_Y:    cfg_next.origin_y       = pwdata[15:0];
                REG_RESOLUTION:  cfg_next.resolution     = pwdata[15:0];
                REG_GRID_COLS:   cfg_next.grid_cols      = pwdata[8:0];
                REG_GRID_ROWS:   cfg_next.grid_rows      = pwdata[8:0];
                REG_KERNEL_COLS: cfg_next.kernel_cols    = pwdata[5:0];
                REG_KERNEL_ROWS: cfg_next.kernel_rows    = pwdata[5:0];
                REG_OCC_VALUE:   cfg_next.occupied_value = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ORIGIN_X:    prdata = {16'h0, cfg_reg.origin_x};
            REG_ORIGIN_Y:    prdata = {16'h0, cfg_reg.origin_y};
            REG_RESOLUTION:  prdata = {16'h0, cfg_reg.resolution};
            REG_GRID_COLS:   prdata = {23'h0, cfg_reg.grid_cols};
            REG_GRID_ROWS:   prdata = {23'h0, cfg_reg.grid_rows};
            REG_KERNEL_COLS: prdata = {26'h0, cfg_reg.kernel_cols};
            REG_KERNEL_ROWS: prdata = {26'h0, cfg_reg.kernel_rows};
            REG_OCC_VALUE:   prdata = {24'h0, cfg_reg.occupied_value};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x       <= '0;
            cfg_reg.origin_y       <= '0;
            cfg_reg.resolution     <= 16'd256;
            cfg_reg.grid_cols      <= 9'd256;
            cfg_reg.grid_rows      <= 9'd256;
            cfg_reg.kernel_cols    <= '0;
            cfg_reg.kernel_rows    <= '0;
            cfg_reg.occupied_value <= 8'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== src/occupancy_grid_rasterizer.sv =====
// Top level of the occupancy grid rasterizer: sequencer, mark memory, divider.
// Depends on ogr_pkg, ogr_ram, ogr_div, ogr_cfg and the defines header.
//
//   channel  | handshake         | word
//   ---------+-------------------+------------
//   in       | in_valid/in_stall | in_word_t
//   out      | out_valid/out_stall | out_word_t
//   cfg      | APB psel/penable  | 32-bit data
//
// Query/readout: S_DIV, S_CHECK, S_Q_RD (skipped outside the grid), then S_RES and the result register.
// Add: S_DIV and S_CHECK, then a read-modify-write for the point and one per dilated column
// (each of one 256-bit column word). Clear: stays in S_IDLE.
// Column words carry a valid bit each, so a clear empties the grid at once.
// A waiting result does not block the next item; only a second result waits.
// Reset empties the grid, idles the sequencer and drops any waiting result.
module occupancy_grid_rasterizer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ogr_pkg::in_word_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ogr_pkg::out_word_t          out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ogr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ogr_pkg::*;
    `include "occupancy_grid_rasterizer_defines.svh"

    localparam int RA_W = $clog2(MAX_ROWS);

    cfg_t      cfg;
    state_t    state_reg, state_next;
    in_word_t  item_reg;
    out_word_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;
    logic [MAX_COLS-1:0] valid_reg, valid_next;

    logic             neg_a_reg, neg_b_reg;
    logic [CA_W-1:0]  col_reg;
    logic [RA_W-1:0]  row_reg;
    logic             inside_reg, rect_reg;
    logic [EC_W-1:0]  c_cur_reg, c_end_reg;
    logic [ER_W-1:0]  r0_reg, r1_reg;

    div_req_t         div_req;
    logic             div_done;
    logic [DIV_W-1:0] quo_a, quo_b;
    logic [RES_W-1:0] rem_a;

    logic                ram_we, ram_re;
    logic [CA_W-1:0]     ram_waddr, ram_raddr;
    logic [MAX_ROWS-1:0] ram_wdata, ram_rdata, old_word, rect_mask;

    logic [EC_W-1:0] eff_cols;
    logic [ER_W-1:0] eff_rows;
    logic [RES_W-1:0] res_eff;
    logic signed [DIV_W-1:0] dx, dy;
    logic accept;

    logic signed [SW-1:0] col_s, row_s, hc, hr, c0, c1, r0, r1, ecs, ers;
    logic [5:0] kcs, krs;
    logic inside_c, rect_c;

    ogr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ogr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo_a (quo_a),
        .quo_b (quo_b),
        .rem_a (rem_a)
    );

    ogr_ram #(
        .WIDTH (MAX_ROWS),
        .DEPTH (MAX_COLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign eff_cols = (32'(cfg.grid_cols) > MAX_COLS) ? EC_W'(MAX_COLS) : EC_W'(cfg.grid_cols);
    assign eff_rows = (32'(cfg.grid_rows) > MAX_ROWS) ? ER_W'(MAX_ROWS) : ER_W'(cfg.grid_rows);
    assign res_eff  = (cfg.resolution == '0) ? RES_W'(1) : cfg.resolution;
    assign kcs = (32'(cfg.kernel_cols) > MAX_KERNEL) ? 6'(MAX_KERNEL) : cfg.kernel_cols;
    assign krs = (32'(cfg.kernel_rows) > MAX_KERNEL) ? 6'(MAX_KERNEL) : cfg.kernel_rows;

    assign dy = {in_data.map_y[23], in_data.map_y} - {cfg.origin_y[15], cfg.origin_y, 8'h00};
    assign dx = {in_data.map_x[23], in_data.map_x} - {cfg.origin_x[15], cfg.origin_x, 8'h00};

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        ecs = $signed(SW'(eff_cols));
        ers = $signed(SW'(eff_rows));
        hc  = $signed(SW'(kcs >> 1));
        hr  = $signed(SW'(krs >> 1));
        if (item_reg.func == FUNC_READ)
        begin
            col_s = $signed(SW'(quo_a));
            row_s = $signed(SW'(rem_a));
            inside_c = (32'(item_reg.cell_index) < 32'(eff_cols) * 32'(eff_rows));
        end
        else
        begin
            col_s = neg_a_reg ? -$signed(SW'(quo_a)) : $signed(SW'(quo_a));
            row_s = neg_b_reg ? -$signed(SW'(quo_b)) : $signed(SW'(quo_b));
            inside_c = (col_s >= 0) && (col_s < ecs) && (row_s >= 0) && (row_s < ers);
        end
        c0 = col_s - hc;
        c1 = col_s + hc;
        r0 = row_s - hr;
        r1 = row_s + hr;
        if (c0 < 0) c0 = '0;
        if (c0 > ecs) c0 = ecs;
        if (c1 < 0) c1 = '0;
        if (c1 > ecs) c1 = ecs;
        if (r0 < 0) r0 = '0;
        if (r0 > ers) r0 = ers;
        if (r1 < 0) r1 = '0;
        if (r1 > ers) r1 = ers;
        rect_c = item_reg.dilate && (c0 < c1) && (r0 < r1);
    end

    assign old_word  = valid_reg[ram_waddr] ? ram_rdata : '0;
    assign rect_mask = ({MAX_ROWS{1'b1}} << r0_reg) & ~({MAX_ROWS{1'b1}} << r1_reg);

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_req.start  = 1'b0;
        div_req.num_a  = dy[DIV_W-1] ? DIV_W'(-dy) : DIV_W'(dy);
        div_req.num_b  = dx[DIV_W-1] ? DIV_W'(-dx) : DIV_W'(dx);
        div_req.den    = res_eff;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = col_reg;
        ram_raddr      = col_reg;
        ram_wdata      = '0;
        if (in_data.func == FUNC_READ)
        begin
            div_req.num_a = DIV_W'(in_data.cell_index);
            div_req.num_b = '0;
            div_req.den   = (eff_rows == '0) ? RES_W'(1) : RES_W'(eff_rows);
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.func == FUNC_CLEAR ||
                        (in_data.func == FUNC_ADD && in_data.new_cloud))
                    begin
                        valid_next = '0;
                    end
                    if (in_data.func != FUNC_CLEAR)
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (item_reg.func == FUNC_ADD)
                begin
                    if (inside_c)
                        state_next = S_PT_RD;
                    else if (rect_c)
                        state_next = S_RC_RD;
                    else
                        state_next = S_IDLE;
                end
                else if (inside_c)
                    state_next = S_Q_RD;
                else
                    state_next = S_RES;
            end
            S_PT_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_PT_WR;
            end
            S_PT_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = old_word | (MAX_ROWS'(1) << row_reg);
                valid_next[col_reg] = 1'b1;
                state_next = rect_reg ? S_RC_RD : S_IDLE;
            end
            S_RC_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = c_cur_reg[CA_W-1:0];
                state_next = S_RC_WR;
            end
            S_RC_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = c_cur_reg[CA_W-1:0];
                ram_wdata  = old_word | rect_mask;
                valid_next[c_cur_reg[CA_W-1:0]] = 1'b1;
                state_next = (c_cur_reg + 1'b1 == c_end_reg) ? S_IDLE : S_RC_RD;
            end
            S_Q_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_next.in_grid  = inside_reg;
                    out_next.occupancy = (inside_reg && valid_reg[col_reg] && ram_rdata[row_reg])
                                       ? cfg.occupied_value : 8'h00;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            item_reg  <= in_data;
            neg_a_reg <= dy[DIV_W-1];
            neg_b_reg <= dx[DIV_W-1];
        end
        if (state_reg == S_CHECK)
        begin
            col_reg    <= CA_W'(col_s);
            row_reg    <= RA_W'(row_s);
            inside_reg <= inside_c;
            rect_reg   <= rect_c;
            c_cur_reg  <= EC_W'(c0);
            c_end_reg  <= EC_W'(c1);
            r0_reg     <= ER_W'(r0);
            r1_reg     <= ER_W'(r1);
        end
        else if (state_reg == S_RC_WR)
        begin
            c_cur_reg <= c_cur_reg + 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `OGR_ASSERT_IMP(a_no_rw_overlap, ram_we, !ram_re, "memory read and write in one cycle")
    `OGR_ASSERT_IMP(a_rect_bound, state_reg == S_RC_WR, c_cur_reg < c_end_reg, "column beyond rectangle")
    `OGR_ASSERT_IMP(a_div_state, div_done, state_reg == S_DIV, "divider finished outside wait")
    `OGR_ASSERT_NXT(a_clear, accept && in_data.func == FUNC_CLEAR, valid_reg == '0, "clear left marks")
endmodule
